[design/matrix_multiply_4x4_assert.svh]
// assertion macros used by the matrix multiplier top level
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mm4_pkg.sv]
// types, constants and microcode program of the matrix multiplier
package mm4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CELLS     = 16;
  localparam logic [3:0] LAST_CELL = 4'd15;

  typedef logic [2:0] step_t;

  localparam step_t STEP_LOAD    = 3'd0;
  localparam step_t STEP_CLEAR   = 3'd1;
  localparam step_t STEP_MAC     = 3'd2;
  localparam step_t STEP_DRAIN_A = 3'd3;
  localparam step_t STEP_DRAIN_B = 3'd4;
  localparam step_t STEP_EMIT    = 3'd5;
  localparam step_t STEP_NEXT    = 3'd6;
  localparam step_t STEP_RETURN  = 3'd7;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_NOT_LAST,
    COND_TERM_MORE,
    COND_OUT_BUSY,
    COND_CELL_MORE,
    COND_ALWAYS
  } cond_t;

  // datapath controls of one microcode step
  typedef struct packed {
    logic accept_in;
    logic clr;
    logic issue;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t target;
  } uword_t;

  // flags the datapath reports back
  typedef struct packed {
    logic term_last;
    logic cell_wrap;
  } dp_stat_t;

  // everything the sequencer branches on
  typedef struct packed {
    logic last_pair;
    logic out_busy;
    logic term_last;
    logic cell_wrap;
  } seq_stat_t;

  function automatic uword_t mm4_ucode(input step_t s);
    uword_t w;
    unique case (s)
      STEP_LOAD:    w = '{'{1'b1, 1'b0, 1'b0, 1'b0}, COND_NOT_LAST,  STEP_LOAD};
      STEP_CLEAR:   w = '{'{1'b0, 1'b1, 1'b0, 1'b0}, COND_NEXT,      STEP_LOAD};
      STEP_MAC:     w = '{'{1'b0, 1'b0, 1'b1, 1'b0}, COND_TERM_MORE, STEP_MAC};
      STEP_DRAIN_A: w = '{'{1'b0, 1'b0, 1'b0, 1'b0}, COND_NEXT,      STEP_LOAD};
      STEP_DRAIN_B: w = '{'{1'b0, 1'b0, 1'b0, 1'b0}, COND_NEXT,      STEP_LOAD};
      STEP_EMIT:    w = '{'{1'b0, 1'b0, 1'b0, 1'b1}, COND_OUT_BUSY,  STEP_EMIT};
      STEP_NEXT:    w = '{'{1'b0, 1'b0, 1'b0, 1'b0}, COND_CELL_MORE, STEP_CLEAR};
      STEP_RETURN:  w = '{'{1'b0, 1'b0, 1'b0, 1'b0}, COND_ALWAYS,    STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

[design/matrix_multiply_4x4.sv]
// top level of the 4x4 fixed-point matrix multiplier
//
//  channel  dir  tdata fields (low bit up)                      tlast         tuser
//  in_      in   left_element, right_element                    final_pair    -
//  out_     out  product_index, product_value                   product_last  -
//
// loading takes one element pair a cycle; the pair with tlast starts the product
// each product element runs clear, 16 half-width multiply passes through the one shared
// multiplier, the pipeline drain steps DRAIN_A and DRAIN_B, emit and branch
// after all 16 product elements are emitted, loading opens again
// a stalled output register holds the sequencer in its emit step
// rst_n clears the step counter, counters and output valid; the stores are not cleared
`include "matrix_multiply_4x4_assert.svh"

module matrix_multiply_4x4 import mm4_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // left_element, right_element, zero pad to bytes
  input  logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // product_index, product_value, zero pad to bytes
  output logic [((4 + DATA_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic out_tlast
);

  localparam int DW    = DATA_WIDTH;
  localparam int OUT_W = ((4 + DW + 7) / 8) * 8;

  ctrl_t     ctrl;
  dp_stat_t  dp_stat;
  seq_stat_t seq_stat;

  logic          in_fire, emit_fire, out_busy;
  logic [3:0]    cell_idx;
  logic [DW-1:0] value;

  logic          out_valid_r;
  logic [3:0]    out_index_r;
  logic [DW-1:0] out_value_r;
  logic          out_last_r;
  logic          out_last_ok;

  // input only open in the load step
  assign in_tready = ctrl.accept_in;
  assign in_fire   = in_tvalid & in_tready;

  // a result may be loaded in the same cycle the old one leaves
  assign out_busy  = out_valid_r & ~out_tready;
  assign emit_fire = ctrl.emit & ~out_busy;

  assign seq_stat.last_pair = in_fire & in_tlast;
  assign seq_stat.out_busy  = out_busy;
  assign seq_stat.term_last = dp_stat.term_last;
  assign seq_stat.cell_wrap = dp_stat.cell_wrap;

  mm4_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (seq_stat),
    .ctrl_o (ctrl)
  );

  mm4_dp #(
    .DATA_WIDTH (DW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (ctrl),
    .load_we_i   (in_fire),
    .load_last_i (in_tlast),
    .left_i      (in_tdata[DW-1:0]),
    .right_i     (in_tdata[2*DW-1:DW]),
    .emit_i      (emit_fire),
    .stat_o      (dp_stat),
    .cell_o      (cell_idx),
    .value_o     (value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_index_r <= cell_idx;
      out_value_r <= value;
      out_last_r  <= (cell_idx == LAST_CELL);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_value_r, out_index_r});
  assign out_tlast  = out_last_r;

  // tlast agrees with the final index
  assign out_last_ok = (out_tlast == (out_index_r == LAST_CELL));

  // loading never overlaps the product sequence
  `MM4_ASSERT_NOW(a_load_excl, in_tready, !(ctrl.issue || ctrl.emit || ctrl.clr), "load overlap")
  // the pair with tlast closes the input until the product is done
  `MM4_ASSERT_NEXT(a_last_closes, in_fire && in_tlast, !in_tready, "input open after last")
  // an emitted element shows up with tlast only on the final index
  `MM4_ASSERT_NEXT(a_emit_lands, emit_fire, out_tvalid && out_last_ok, "emit lost or mismarked")

endmodule

[design/mm4_seq.sv]
// microcode sequencer: step counter, program rom and branch logic
module mm4_seq import mm4_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat_i,
  output ctrl_t     ctrl_o
);

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   take;

  assign uw     = mm4_ucode(step_r);
  assign ctrl_o = uw.ctrl;

  always_comb begin
    unique case (uw.cond)
      COND_NEXT:      take = 1'b0;
      COND_NOT_LAST:  take = !stat_i.last_pair;
      COND_TERM_MORE: take = !stat_i.term_last;
      COND_OUT_BUSY:  take = stat_i.out_busy;
      COND_CELL_MORE: take = !stat_i.cell_wrap;
      COND_ALWAYS:    take = 1'b1;
      default:        take = 1'b0;
    endcase
    step_nxt = take ? uw.target : step_t'(step_r + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[design/mm4_dp.sv]
// datapath: element stores, shared half-width multiplier, accumulator, saturation
module mm4_dp import mm4_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctrl_i,
  input  logic                  load_we_i,
  input  logic                  load_last_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic                  emit_i,
  output dp_stat_t              stat_o,
  output logic [3:0]            cell_o,
  output logic [DATA_WIDTH-1:0] value_o
);

  localparam int DW = DATA_WIDTH;
  localparam int H  = (DW + 1) / 2;   // low half width
  localparam int HI = DW - H;         // high half width
  localparam int PW = 2 * H + 2;      // partial product width
  localparam int AW = 2 * DW + 2;     // exact sum of four products

  logic [DW-1:0] left_mem  [CELLS];
  logic [DW-1:0] right_mem [CELLS];

  logic [3:0] load_pos_r;
  logic [3:0] term_r;   // k in [3:2], half select in [1:0]
  logic [3:0] cell_r;
  logic [3:0] laddr, raddr;

  logic [DW-1:0] lrd_r, rrd_r;
  logic          s1_valid_r, s2_valid_r;
  logic [1:0]    s1_part_r, s2_shift_r;

  logic signed [H:0]    a_op, b_op;
  logic signed [PW-1:0] pp_r;
  logic signed [AW-1:0] pp_ext, addend, acc_r, sh;
  logic [AW-DW:0]       hi_bits;
  logic                 fits;

  // row + 4k for the left store, k + 4col for the right store
  assign laddr = {term_r[3:2], cell_r[1:0]};
  assign raddr = {cell_r[3:2], term_r[3:2]};

  always_ff @(posedge clk) begin
    if (load_we_i) begin
      left_mem[load_pos_r]  <= left_i;
      right_mem[load_pos_r] <= right_i;
    end
    lrd_r <= left_mem[laddr];
    rrd_r <= right_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      term_r     <= '0;
      cell_r     <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (load_we_i) begin
        load_pos_r <= load_last_i ? 4'd0 : load_pos_r + 4'd1;
      end
      if (ctrl_i.clr) begin
        term_r <= '0;
      end else if (ctrl_i.issue) begin
        term_r <= term_r + 4'd1;
      end
      if (emit_i) begin
        cell_r <= cell_r + 4'd1;
      end
      s1_valid_r <= ctrl_i.issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  // signed high half, unsigned low half, both in h+1 signed bits
  always_comb begin
    a_op = s1_part_r[1] ? signed'({{(H + 1 - HI){lrd_r[DW-1]}}, lrd_r[DW-1:H]})
                        : signed'({1'b0, lrd_r[H-1:0]});
    b_op = s1_part_r[0] ? signed'({{(H + 1 - HI){rrd_r[DW-1]}}, rrd_r[DW-1:H]})
                        : signed'({1'b0, rrd_r[H-1:0]});
  end

  always_ff @(posedge clk) begin
    s1_part_r  <= term_r[1:0];
    pp_r       <= a_op * b_op;
    s2_shift_r <= {1'b0, s1_part_r[1]} + {1'b0, s1_part_r[0]};
  end

  always_comb begin
    pp_ext = signed'({{(AW - PW){pp_r[PW-1]}}, pp_r});
    unique case (s2_shift_r)
      2'd0:    addend = pp_ext;
      2'd1:    addend = pp_ext <<< H;
      2'd2:    addend = pp_ext <<< (2 * H);
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.clr) begin
      acc_r <= '0;
    end else if (s2_valid_r) begin
      acc_r <= acc_r + addend;
    end
  end

  // arithmetic shift then clamp to data width
  always_comb begin
    sh      = acc_r >>> FRAC_BITS;
    hi_bits = sh[AW-1:DW-1];
    fits    = (&hi_bits) | ~(|hi_bits);
    if (fits) begin
      value_o = sh[DW-1:0];
    end else if (acc_r[AW-1]) begin
      value_o = {1'b1, {(DW - 1){1'b0}}};
    end else begin
      value_o = {1'b0, {(DW - 1){1'b1}}};
    end
  end

  assign cell_o           = cell_r;
  assign stat_o.term_last = (term_r == LAST_CELL);
  assign stat_o.cell_wrap = (cell_r == 4'd0);

endmodule
